// ===== sv/iat_pkg.sv =====
// Shared types, codes and lifecycle helpers of the idempotent action table.
package iat_pkg;

  localparam int unsigned SlotIdxW = 8;

  localparam logic [3:0] ST_NONE      = 4'd0;
  localparam logic [3:0] ST_CREATED   = 4'd1;
  localparam logic [3:0] ST_OBSERVING = 4'd2;
  localparam logic [3:0] ST_PLANNED   = 4'd3;
  localparam logic [3:0] ST_RUNNING   = 4'd4;
  localparam logic [3:0] ST_VERIFYING = 4'd5;
  localparam logic [3:0] ST_SUCCEEDED = 4'd6;
  localparam logic [3:0] ST_FAILED    = 4'd7;
  localparam logic [3:0] ST_UNKNOWN   = 4'd8;
  localparam logic [3:0] ST_CANCELLED = 4'd9;

  localparam logic [2:0] RSP_NEW         = 3'd0;
  localparam logic [2:0] RSP_REPLAY      = 3'd1;
  localparam logic [2:0] RSP_IN_PROGRESS = 3'd2;
  localparam logic [2:0] RSP_ID_REUSED   = 3'd3;
  localparam logic [2:0] RSP_FULL        = 3'd4;
  localparam logic [2:0] RSP_ADVANCED    = 3'd5;
  localparam logic [2:0] RSP_REJECTED    = 3'd6;

  localparam logic FUNC_BEGIN   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [0:0] REG_DEDUP_DISABLED = 1'b0;

  typedef struct packed {
    logic        func;
    logic [63:0] action_key;
    logic [63:0] fingerprint;
    logic [3:0]  target_slot;
    logic [3:0]  target_state;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_found;
    logic [3:0]  entry_state;
    logic [31:0] entry_seq;
    logic [31:0] started_count;
    logic [31:0] replayed_count;
    logic [31:0] evicted_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0]         key;
    logic [63:0]         fp;
    logic [3:0]          tslot;
    logic                m_have;
    logic [SlotIdxW-1:0] m_slot;
    logic [31:0]         m_seq;
    logic [3:0]          m_state;
    logic                m_fp_eq;
    logic                free_have;
    logic [SlotIdxW-1:0] free_slot;
    logic                fin_have;
    logic [SlotIdxW-1:0] fin_slot;
    logic [31:0]         fin_seq;
    logic [3:0]          tgt_state;
    logic [31:0]         tgt_seq;
  } scan_t;

  typedef struct packed {
    logic                create;
    logic                set_state;
    logic [SlotIdxW-1:0] slot;
    logic [63:0]         key;
    logic [63:0]         fp;
    logic [31:0]         seq;
    logic [3:0]          state;
  } wr_t;

  function automatic logic is_final(logic [3:0] s);
    return (s == ST_SUCCEEDED) || (s == ST_FAILED) || (s == ST_UNKNOWN) ||
           (s == ST_CANCELLED);
  endfunction

  function automatic logic edge_allowed(logic [3:0] from, logic [3:0] to);
    logic ok;
    case (from)
      ST_CREATED:   ok = (to == ST_OBSERVING) || (to == ST_FAILED);
      ST_OBSERVING: ok = (to == ST_PLANNED) || (to == ST_FAILED);
      ST_PLANNED:   ok = (to == ST_RUNNING) || (to == ST_FAILED) || (to == ST_CANCELLED);
      ST_RUNNING:   ok = (to == ST_VERIFYING) || (to == ST_FAILED) || (to == ST_UNKNOWN);
      ST_VERIFYING: ok = (to == ST_SUCCEEDED) || (to == ST_FAILED) || (to == ST_UNKNOWN);
      default:      ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== sv/iat_cell.sv =====
// One table slot: holds a record and folds it into the passing scan transaction.
module iat_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  iat_pkg::scan_t pkt_i,
  input  iat_pkg::wr_t  wr_i,
  output logic          vld_o,
  output iat_pkg::scan_t pkt_o
);

  logic [63:0]          key_q;
  logic [63:0]          fp_q;
  logic [31:0]          seq_q;
  logic [3:0]           st_q;
  logic                 vld_q;
  iat_pkg::scan_t       pkt_q;
  iat_pkg::scan_t       pkt_d;
  logic                 hit;
  logic [iat_pkg::SlotIdxW-1:0] my_idx;

  assign my_idx = iat_pkg::SlotIdxW'(Idx);
  assign hit    = (wr_i.slot == my_idx);

  always_comb begin
    pkt_d = pkt_i;
    if ((st_q != iat_pkg::ST_NONE) && (key_q == pkt_i.key) &&
        (!pkt_i.m_have || (seq_q > pkt_i.m_seq))) begin
      pkt_d.m_have  = 1'b1;
      pkt_d.m_slot  = my_idx;
      pkt_d.m_seq   = seq_q;
      pkt_d.m_state = st_q;
      pkt_d.m_fp_eq = (fp_q == pkt_i.fp);
    end
    if (!pkt_i.free_have && (st_q == iat_pkg::ST_NONE)) begin
      pkt_d.free_have = 1'b1;
      pkt_d.free_slot = my_idx;
    end
    if (iat_pkg::is_final(st_q) && (!pkt_i.fin_have || (seq_q < pkt_i.fin_seq))) begin
      pkt_d.fin_have = 1'b1;
      pkt_d.fin_slot = my_idx;
      pkt_d.fin_seq  = seq_q;
    end
    if ({4'b0000, pkt_i.tslot} == my_idx) begin
      pkt_d.tgt_state = st_q;
      pkt_d.tgt_seq   = seq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      st_q  <= iat_pkg::ST_NONE;
    end else begin
      vld_q <= vld_i;
      if (hit && wr_i.create) begin
        st_q <= iat_pkg::ST_CREATED;
      end else if (hit && wr_i.set_state) begin
        st_q <= wr_i.state;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      pkt_q <= pkt_d;
    end
    if (hit && wr_i.create) begin
      key_q <= wr_i.key;
      fp_q  <= wr_i.fp;
      seq_q <= wr_i.seq;
    end
  end

  assign vld_o = vld_q;
  assign pkt_o = pkt_q;

endmodule

// ===== sv/idempotent_action_table.sv =====
// Top level of the idempotent action table: request control, counters and register port.
//
// Requests enter on the in channel (valid/ready, req_t payload) and each gives exactly
// one response on the out channel (valid/ready, rsp_t payload). A begin request looks
// up the newest live record with its key unless dedup is disabled, then falls back to
// the first free slot or the oldest finished record; an advance request moves one slot
// along its lifecycle. Each request travels as a scan transaction through a row of
// SLOTS cells, one cell per cycle, then decides and updates the chosen slot in the
// finish state. The response is registered as the request leaves that state; a new
// request is taken only in the idle state, so only one request is in the block at a time.
// The response sits in an output register: a stalled receiver holds it there, the
// next request may be accepted and scanned meanwhile, and its update waits until the
// register is free. Reset empties every slot, sets the sequence number to one, clears
// the counters and enables dedup; no clearing pass is needed.
// Register 0 at address 0, dedup_disabled in bit 0, is written over the APB port. The
// user must write it only while no request is in the block; the block does not enforce it.
module idempotent_action_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iat_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output iat_pkg::rsp_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e          state_q;
  logic            dedup_dis_q;
  logic            out_valid_q;
  iat_pkg::rsp_t   out_q;
  iat_pkg::rsp_t   rsp_d;
  iat_pkg::scan_t  last_q;
  iat_pkg::req_t   req_q;
  logic [31:0]     next_seq_q;
  logic [31:0]     started_q;
  logic [31:0]     replayed_q;
  logic [31:0]     evicted_q;
  logic [31:0]     started_d;
  logic [31:0]     replayed_d;
  logic [31:0]     evicted_d;
  iat_pkg::wr_t    wr;
  iat_pkg::scan_t  init_pkt;
  iat_pkg::scan_t  chain_pkt [SLOTS+1];
  logic [SLOTS:0]  chain_vld;
  logic            in_fire;
  logic            fin_fire;
  logic            cfg_wr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_fire   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    init_pkt       = '0;
    init_pkt.key   = in_data_i.action_key;
    init_pkt.fp    = in_data_i.fingerprint;
    init_pkt.tslot = in_data_i.target_slot;
  end

  assign chain_vld[0] = in_fire;
  assign chain_pkt[0] = init_pkt;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    iat_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (chain_vld[g]),
      .pkt_i (chain_pkt[g]),
      .wr_i  (wr),
      .vld_o (chain_vld[g+1]),
      .pkt_o (chain_pkt[g+1])
    );
  end

  always_comb begin
    wr         = '0;
    wr.key     = req_q.action_key;
    wr.fp      = req_q.fingerprint;
    wr.seq     = next_seq_q;
    wr.state   = req_q.target_state;
    started_d  = started_q;
    replayed_d = replayed_q;
    evicted_d  = evicted_q;
    rsp_d      = '0;
    if (req_q.func == iat_pkg::FUNC_ADVANCE) begin
      if (32'(req_q.target_slot) >= SLOTS) begin
        rsp_d.status = iat_pkg::RSP_REJECTED;
      end else if (iat_pkg::edge_allowed(last_q.tgt_state, req_q.target_state)) begin
        rsp_d.status      = iat_pkg::RSP_ADVANCED;
        rsp_d.slot_found  = req_q.target_slot;
        rsp_d.entry_state = req_q.target_state;
        rsp_d.entry_seq   = last_q.tgt_seq;
        wr.set_state      = fin_fire;
        wr.slot           = {4'b0000, req_q.target_slot};
      end else begin
        rsp_d.status      = iat_pkg::RSP_REJECTED;
        rsp_d.slot_found  = req_q.target_slot;
        rsp_d.entry_state = last_q.tgt_state;
        rsp_d.entry_seq   = (last_q.tgt_state != iat_pkg::ST_NONE) ? last_q.tgt_seq : '0;
      end
    end else if (!dedup_dis_q && last_q.m_have) begin
      rsp_d.slot_found  = last_q.m_slot[3:0];
      rsp_d.entry_state = last_q.m_state;
      rsp_d.entry_seq   = last_q.m_seq;
      if (!last_q.m_fp_eq) begin
        rsp_d.status = iat_pkg::RSP_ID_REUSED;
      end else if (!iat_pkg::is_final(last_q.m_state)) begin
        rsp_d.status = iat_pkg::RSP_IN_PROGRESS;
      end else begin
        rsp_d.status = iat_pkg::RSP_REPLAY;
        replayed_d   = replayed_q + 32'd1;
      end
    end else if (last_q.free_have || last_q.fin_have) begin
      wr.create         = fin_fire;
      wr.slot           = last_q.free_have ? last_q.free_slot : last_q.fin_slot;
      rsp_d.status      = iat_pkg::RSP_NEW;
      rsp_d.slot_found  = wr.slot[3:0];
      rsp_d.entry_state = iat_pkg::ST_CREATED;
      rsp_d.entry_seq   = next_seq_q;
      started_d         = started_q + 32'd1;
      if (!last_q.free_have) begin
        evicted_d = evicted_q + 32'd1;
      end
    end else begin
      rsp_d.status = iat_pkg::RSP_FULL;
    end
    rsp_d.started_count  = started_d;
    rsp_d.replayed_count = replayed_d;
    rsp_d.evicted_count  = evicted_d;
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dedup_dis_q <= 1'b0;
      next_seq_q  <= 32'd1;
      started_q   <= '0;
      replayed_q  <= '0;
      evicted_q   <= '0;
    end else begin
      if (cfg_wr && (paddr[2] == iat_pkg::REG_DEDUP_DISABLED)) begin
        dedup_dis_q <= pwdata[0];
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain_vld[SLOTS]) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_fire) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            started_q   <= started_d;
            replayed_q  <= replayed_d;
            evicted_q   <= evicted_d;
            if (wr.create) begin
              next_seq_q <= next_seq_q + 32'd1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    if ((state_q == S_SCAN) && chain_vld[SLOTS]) begin
      last_q <= chain_pkt[SLOTS];
    end
    if (fin_fire) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == iat_pkg::REG_DEDUP_DISABLED) ? {31'd0, dedup_dis_q} : '0;

  a_scan_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> chain_vld[1])
    else $error("accepted request did not enter the first cell");

  a_single_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld[SLOTS:1]))
    else $error("more than one scan transaction in the cell row");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.create || wr.set_state) |-> (chain_vld[SLOTS:1] == '0))
    else $error("slot update while a scan is in flight");

  a_seq_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_seq_q == (started_q + 32'd1))
    else $error("sequence number out of step with created count");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the idempotent action table: directed and random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS    = 16;
  localparam int KEY_POOL       = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;

  logic           clk_i;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  iat_pkg::req_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  iat_pkg::rsp_t  out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  idempotent_action_table #(.SLOTS(TABLE_SLOTS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Table shadow
  logic [63:0] rec_key   [TABLE_SLOTS];
  logic [63:0] rec_fp    [TABLE_SLOTS];
  logic [31:0] rec_seq   [TABLE_SLOTS];
  logic [3:0]  rec_state [TABLE_SLOTS];
  logic [31:0] seq_next = 32'd1;
  logic [31:0] started_n = '0;
  logic [31:0] replayed_n = '0;
  logic [31:0] evicted_n = '0;
  logic        dedup_off = 1'b0;

  iat_pkg::req_t req_q[$];
  iat_pkg::rsp_t expected_rsp_q[$];
  logic [63:0]   key_pool [KEY_POOL];
  logic [63:0]   fp_pool  [KEY_POOL];

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned rsp_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        hold_done = 1'b0;

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      rec_key[i] = '0;
      rec_fp[i] = '0;
      rec_seq[i] = '0;
      rec_state[i] = iat_pkg::ST_NONE;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic is_settled(logic [3:0] s);
    return s inside {iat_pkg::ST_SUCCEEDED, iat_pkg::ST_FAILED, iat_pkg::ST_UNKNOWN,
                     iat_pkg::ST_CANCELLED};
  endfunction

  function automatic logic lifecycle_step_ok(logic [3:0] from, logic [3:0] to);
    case (from)
      iat_pkg::ST_CREATED:
        return to inside {iat_pkg::ST_OBSERVING, iat_pkg::ST_FAILED};
      iat_pkg::ST_OBSERVING:
        return to inside {iat_pkg::ST_PLANNED, iat_pkg::ST_FAILED};
      iat_pkg::ST_PLANNED:
        return to inside {iat_pkg::ST_RUNNING, iat_pkg::ST_FAILED, iat_pkg::ST_CANCELLED};
      iat_pkg::ST_RUNNING:
        return to inside {iat_pkg::ST_VERIFYING, iat_pkg::ST_FAILED, iat_pkg::ST_UNKNOWN};
      iat_pkg::ST_VERIFYING:
        return to inside {iat_pkg::ST_SUCCEEDED, iat_pkg::ST_FAILED, iat_pkg::ST_UNKNOWN};
      default:
        return 1'b0;
    endcase
  endfunction

  // Apply one request to the shadow table and return the response it must produce.
  function automatic iat_pkg::rsp_t table_response(iat_pkg::req_t r);
    iat_pkg::rsp_t o;
    int   pick;
    logic have;
    logic has_slot;
    o = '0;
    pick = 0;
    have = 1'b0;
    has_slot = 1'b1;
    if (r.func == iat_pkg::FUNC_ADVANCE) begin
      pick = int'(r.target_slot);
      if (r.target_slot >= TABLE_SLOTS) begin
        o.status = iat_pkg::RSP_REJECTED;
        has_slot = 1'b0;
      end else if (lifecycle_step_ok(rec_state[pick], r.target_state)) begin
        rec_state[pick] = r.target_state;
        o.status = iat_pkg::RSP_ADVANCED;
      end else begin
        o.status = iat_pkg::RSP_REJECTED;
      end
    end else begin
      if (!dedup_off) begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (rec_state[i] != iat_pkg::ST_NONE && rec_key[i] == r.action_key &&
              (!have || rec_seq[i] > rec_seq[pick])) begin
            pick = i;
            have = 1'b1;
          end
        end
      end
      if (have) begin
        if (rec_fp[pick] != r.fingerprint) begin
          o.status = iat_pkg::RSP_ID_REUSED;
        end else if (!is_settled(rec_state[pick])) begin
          o.status = iat_pkg::RSP_IN_PROGRESS;
        end else begin
          replayed_n++;
          o.status = iat_pkg::RSP_REPLAY;
        end
      end else begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!have && rec_state[i] == iat_pkg::ST_NONE) begin
            pick = i;
            have = 1'b1;
          end
        end
        if (!have) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (is_settled(rec_state[i]) && (!have || rec_seq[i] < rec_seq[pick])) begin
              pick = i;
              have = 1'b1;
            end
          end
          if (have) evicted_n++;
        end
        if (!have) begin
          o.status = iat_pkg::RSP_FULL;
          has_slot = 1'b0;
        end else begin
          rec_key[pick] = r.action_key;
          rec_fp[pick] = r.fingerprint;
          rec_seq[pick] = seq_next;
          seq_next++;
          rec_state[pick] = iat_pkg::ST_CREATED;
          started_n++;
          o.status = iat_pkg::RSP_NEW;
        end
      end
    end
    if (has_slot) begin
      o.slot_found = 4'(pick);
      o.entry_state = rec_state[pick];
      if (rec_state[pick] != iat_pkg::ST_NONE) o.entry_seq = rec_seq[pick];
    end
    o.started_count = started_n;
    o.replayed_count = replayed_n;
    o.evicted_count = evicted_n;
    return o;
  endfunction

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_n) begin : request_driver
    logic fire;
    logic nv;
    iat_pkg::req_t nd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      nv = in_valid && !fire;
      nd = in_data;
      if (fire) expected_rsp_q.push_back(table_response(in_data));
      if (!nv) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_q.size() != 0) begin
          nd = req_q.pop_front();
          nv = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  // Receiver: checks each transaction and stalls on its own pattern
  always @(posedge clk_i) begin : response_monitor
    iat_pkg::rsp_t want;
    if (out_valid && out_ready) begin
      rsp_seen++;
      if (expected_rsp_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: response with nothing pending: st=%0d slot=%0d state=%0d seq=%0d",
                   $realtime, out_data.status, out_data.slot_found, out_data.entry_state,
                   out_data.entry_seq);
        mismatches++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_data !== want) begin
          if (mismatches < 10) begin
            $display("%0t: mismatch, expected st=%0d slot=%0d state=%0d seq=%0d cnt=%0d/%0d/%0d",
                     $realtime, want.status, want.slot_found, want.entry_state,
                     want.entry_seq, want.started_count, want.replayed_count,
                     want.evicted_count);
            $display("    actual st=%0d slot=%0d state=%0d seq=%0d cnt=%0d/%0d/%0d",
                     out_data.status, out_data.slot_found, out_data.entry_state,
                     out_data.entry_seq, out_data.started_count, out_data.replayed_count,
                     out_data.evicted_count);
          end
          mismatches++;
        end
      end
    end
    if (!hold_done && rsp_seen >= 300) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 250);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (mode_left % 3 == 0);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic iat_pkg::req_t make_req(logic f, logic [63:0] k, logic [63:0] fp,
                                             logic [3:0] ts, logic [3:0] tst);
    iat_pkg::req_t r;
    r.func = f;
    r.action_key = k;
    r.fingerprint = fp;
    r.target_slot = ts;
    r.target_state = tst;
    return r;
  endfunction

  task automatic drain();
    while (req_q.size() != 0 || in_valid || expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_dedup(input logic v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(iat_pkg::REG_DEDUP_DISABLED) << 2;
    pwdata  <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dedup_off = v;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n, input int begin_pct);
    iat_pkg::req_t r;
    int            live[$];
    int            k;
    int            s;
    logic [3:0]    st;
    repeat (n) begin
      while (req_q.size() >= 2) @(negedge clk_i);
      r.func = iat_pkg::FUNC_ADVANCE;
      r.action_key = {$urandom, $urandom};
      r.fingerprint = {$urandom, $urandom};
      r.target_slot = 4'($urandom_range(0, 15));
      r.target_state = 4'($urandom_range(0, 15));
      k = $urandom_range(0, 99);
      if (k < begin_pct) begin
        r.func = iat_pkg::FUNC_BEGIN;
        if ($urandom_range(0, 9) < 7) begin
          s = $urandom_range(0, KEY_POOL - 1);
          r.action_key = key_pool[s];
          if ($urandom_range(0, 4) != 0) r.fingerprint = fp_pool[s];
        end
      end else if (k < 88) begin
        live.delete();
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (rec_state[i] inside {[iat_pkg::ST_CREATED:iat_pkg::ST_VERIFYING]})
            live.push_back(i);
        if (live.size() != 0) begin
          r.target_slot = 4'(live[$urandom_range(0, live.size() - 1)]);
          st = rec_state[r.target_slot];
          // favour forward progress so records reach the later states
          if ($urandom_range(0, 3) != 0) begin
            r.target_state = st + 4'd1;
          end else begin
            do r.target_state = 4'($urandom_range(1, 9));
            while (!lifecycle_step_ok(st, r.target_state));
          end
        end
      end
      req_q.push_back(r);
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    fp_pool[0] = '1;
    fp_pool[1] = '0;
    for (int i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = {$urandom, $urandom};
      fp_pool[i] = {$urandom, $urandom};
    end
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    write_dedup(1'b0);

    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, '0, '0, 4'd0, 4'd0));
    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, '1, '1, 4'd15, 4'd15));
    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, '0, '0, 4'd5, 4'd10));
    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, '0, '1, 4'd10, 4'd5));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '1, '1, 4'd0, iat_pkg::ST_OBSERVING));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '1, '1, 4'd0, iat_pkg::ST_PLANNED));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '1, '1, 4'd0, iat_pkg::ST_RUNNING));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '1, '1, 4'd0, iat_pkg::ST_VERIFYING));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '1, '1, 4'd0, iat_pkg::ST_SUCCEEDED));
    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, '0, '0, 4'd0, 4'd0));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '0, 4'd0, iat_pkg::ST_FAILED));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '0, 4'd15, iat_pkg::ST_CREATED));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '0, 4'd1, iat_pkg::ST_NONE));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '0, 4'd1, 4'd15));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '0, 4'd1, 4'd10));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '0, 4'd1, iat_pkg::ST_FAILED));
    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, '1, '1, 4'd0, 4'd0));
    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, 64'h5555_5555_5555_5555,
                             64'hAAAA_AAAA_AAAA_AAAA, 4'd2, 4'd2));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '1, 4'd2, iat_pkg::ST_OBSERVING));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '1, 4'd2, iat_pkg::ST_PLANNED));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '1, 4'd2, iat_pkg::ST_CANCELLED));
    req_q.push_back(make_req(iat_pkg::FUNC_ADVANCE, '0, '1, 4'd2, iat_pkg::ST_UNKNOWN));
    req_q.push_back(make_req(iat_pkg::FUNC_BEGIN, 64'h5555_5555_5555_5555,
                             64'hAAAA_AAAA_AAAA_AAAA, 4'd7, 4'd8));

    run_random(420, 45);
    drain();
    write_dedup(1'b1);
    run_random(220, 70);
    drain();
    write_dedup(1'b0);
    run_random(240, 45);
    drain();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/iat_pkg.sv
sv/iat_cell.sv
sv/idempotent_action_table.sv
tb/tb_top.sv
